// ----- hdl/camera_lifecycle_fsm_defines.svh -----
// ----------------------------------------------------------------------------
// Camera lifecycle sequencer - assertion macros
// Shared concurrent assertion forms for the sequencer RTL.
// ----------------------------------------------------------------------------
`ifndef CAMERA_LIFECYCLE_FSM_DEFINES_SVH
`define CAMERA_LIFECYCLE_FSM_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define CLF_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define CLF_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/clfsm_pkg.sv -----
// ----------------------------------------------------------------------------
// Camera lifecycle sequencer - package
// State and event codes and the decoded result type.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package clfsm_pkg;

  localparam int unsigned STATE_W = 3;
  localparam int unsigned EVENT_W = 4;
  localparam int unsigned CAUSE_W = 3;

  typedef logic [STATE_W-1:0] state_t;
  typedef logic [EVENT_W-1:0] event_t;
  typedef logic [CAUSE_W-1:0] cause_t;

  localparam state_t ST_IDLE      = 3'd0;
  localparam state_t ST_OPENING   = 3'd1;
  localparam state_t ST_CAPTURING = 3'd2;
  localparam state_t ST_RETRYING  = 3'd3;
  localparam state_t ST_FAILED    = 3'd4;
  localparam state_t ST_UNAVAIL   = 3'd5;

  localparam event_t EV_TOGGLE      = 4'd0;
  localparam event_t EV_AUTH_OK     = 4'd1;
  localparam event_t EV_AUTH_DENIED = 4'd2;
  localparam event_t EV_OPEN_OK     = 4'd3;
  localparam event_t EV_OPEN_FAIL   = 4'd4;
  localparam event_t EV_FIRST_FRAME = 4'd5;
  localparam event_t EV_WATCHDOG    = 4'd6;
  localparam event_t EV_RUNTIME_ERR = 4'd7;
  localparam event_t EV_RETRY_TICK  = 4'd8;
  localparam event_t EV_RETRY_EXH   = 4'd9;
  localparam event_t EV_RECHECK     = 4'd10;
  localparam event_t EV_SHUTDOWN    = 4'd11;

  localparam cause_t CAUSE_NONE   = 3'd0;
  localparam cause_t CAUSE_IN_USE = 3'd1;

  typedef struct packed {
    state_t next_state;
    logic   start_open;
    logic   close_device;
    logic   start_retry;
    logic   stop_retry;
    logic   start_first_watchdog;
    logic   stop_first_watchdog;
    logic   start_stall_watchdog;
    logic   stop_stall_watchdog;
    logic   fallback_valid;
    cause_t fallback_cause;
  } result_t;

endpackage

`default_nettype wire

// ----- hdl/clfsm_decode.sv -----
// ----------------------------------------------------------------------------
// Camera lifecycle sequencer - transition decode
// Next state, commands and fallback cause for one event in the current state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clfsm_decode (
  input  wire  clfsm_pkg::state_t  cur_state,
  input  wire  clfsm_pkg::event_t  req_type,
  input  wire  clfsm_pkg::cause_t  fallback_hint,
  output clfsm_pkg::result_t       res
);
  import clfsm_pkg::*;

  function automatic cause_t hint_or_default(input cause_t hint);
    return (hint != CAUSE_NONE) ? hint : CAUSE_IN_USE;
  endfunction

  always_comb begin
    res            = '0;
    res.next_state = cur_state;

    if (req_type == EV_SHUTDOWN) begin
      res.next_state          = ST_IDLE;
      res.close_device        = 1'b1;
      res.stop_retry          = 1'b1;
      res.stop_first_watchdog = 1'b1;
      res.stop_stall_watchdog = 1'b1;
    end else begin
      unique case (cur_state)
        ST_IDLE: begin
          if (req_type == EV_TOGGLE) begin
            res.next_state = ST_OPENING;
            res.start_open = 1'b1;
          end
        end
        ST_OPENING: begin
          case (req_type) inside
            EV_AUTH_DENIED: begin
              // raw hint, valid even when none
              res.next_state     = ST_UNAVAIL;
              res.close_device   = 1'b1;
              res.fallback_valid = 1'b1;
              res.fallback_cause = fallback_hint;
            end
            EV_OPEN_OK: begin
              res.start_first_watchdog = 1'b1;
            end
            EV_OPEN_FAIL: begin
              res.next_state          = ST_UNAVAIL;
              res.close_device        = 1'b1;
              res.stop_first_watchdog = 1'b1;
              res.fallback_valid      = 1'b1;
              res.fallback_cause      = fallback_hint;
            end
            EV_FIRST_FRAME: begin
              res.next_state           = ST_CAPTURING;
              res.stop_first_watchdog  = 1'b1;
              res.start_stall_watchdog = 1'b1;
            end
            EV_WATCHDOG: begin
              res.next_state          = ST_UNAVAIL;
              res.close_device        = 1'b1;
              res.stop_first_watchdog = 1'b1;
              res.fallback_valid      = 1'b1;
              res.fallback_cause      = hint_or_default(fallback_hint);
            end
            default: ;
          endcase
        end
        ST_CAPTURING: begin
          case (req_type) inside
            EV_TOGGLE: begin
              res.next_state          = ST_IDLE;
              res.close_device        = 1'b1;
              res.stop_stall_watchdog = 1'b1;
            end
            EV_RUNTIME_ERR, EV_WATCHDOG: begin
              res.next_state          = ST_RETRYING;
              res.close_device        = 1'b1;
              res.stop_stall_watchdog = 1'b1;
              res.start_retry         = 1'b1;
              if (req_type == EV_WATCHDOG) begin
                res.fallback_valid = 1'b1;
                res.fallback_cause = hint_or_default(fallback_hint);
              end else if (fallback_hint != CAUSE_NONE) begin
                res.fallback_valid = 1'b1;
                res.fallback_cause = fallback_hint;
              end
            end
            default: ;
          endcase
        end
        ST_RETRYING: begin
          case (req_type) inside
            EV_RETRY_TICK: begin
              res.next_state = ST_OPENING;
              res.start_open = 1'b1;
            end
            EV_OPEN_OK: begin
              res.next_state           = ST_OPENING;
              res.start_first_watchdog = 1'b1;
            end
            EV_OPEN_FAIL: begin
              res.next_state     = ST_UNAVAIL;
              res.stop_retry     = 1'b1;
              res.close_device   = 1'b1;
              res.fallback_valid = 1'b1;
              res.fallback_cause = hint_or_default(fallback_hint);
            end
            EV_RETRY_EXH: begin
              res.next_state     = ST_UNAVAIL;
              res.stop_retry     = 1'b1;
              res.fallback_valid = 1'b1;
              res.fallback_cause = hint_or_default(fallback_hint);
            end
            EV_TOGGLE: begin
              res.next_state   = ST_IDLE;
              res.close_device = 1'b1;
              res.stop_retry   = 1'b1;
            end
            default: ;
          endcase
        end
        ST_FAILED: begin
          // exit-only state
          case (req_type) inside
            EV_RETRY_TICK: begin
              res.next_state = ST_OPENING;
              res.start_open = 1'b1;
            end
            EV_TOGGLE: begin
              res.next_state   = ST_IDLE;
              res.close_device = 1'b1;
            end
            default: ;
          endcase
        end
        ST_UNAVAIL: begin
          case (req_type) inside
            EV_RECHECK, EV_TOGGLE: begin
              res.next_state = ST_OPENING;
              res.start_open = 1'b1;
            end
            default: ;
          endcase
        end
        default: ;  // unused codes only honor shutdown
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- hdl/camera_lifecycle_fsm.sv -----
// ----------------------------------------------------------------------------
// Camera lifecycle sequencer - top level
// Takes one event beat per cycle when the output keeps up; one command beat per event.
//
// Each input beat carries an event code and a fallback cause hint; each
// output beat carries the new lifecycle state, the start/stop commands and
// an optional fallback cause. One event is taken every clock cycle when the
// output side keeps up. An event is first held in the input register, then
// it is decoded against the state register and lands in the output register.
// The state register updates in the same cycle the result is registered, so
// consecutive events see each other's state with no bubble. A stalled output
// holds its beat while one more event waits in the input register. Reset
// returns the state to idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "camera_lifecycle_fsm_defines.svh"

module camera_lifecycle_fsm (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // [3:0] req_type, [6:4] fallback_hint, [7] zero
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [15:0] out_tdata  // [2:0] next_state, [3] start_open,
                                 // [4] close_device, [5] start_retry,
                                 // [6] stop_retry, [7] start_first_watchdog,
                                 // [8] stop_first_watchdog,
                                 // [9] start_stall_watchdog,
                                 // [10] stop_stall_watchdog,
                                 // [11] fallback_valid, [14:12] fallback_cause,
                                 // [15] zero
);
  import clfsm_pkg::*;

  logic    in_vld_r;
  event_t  in_ev_r;
  cause_t  in_hint_r;
  state_t  cam_state_r;
  logic    out_vld_r;
  result_t out_res_r;
  result_t dec_res;
  logic    adv;

  // input beat moves on when the output register is free or draining
  assign adv       = in_vld_r && (!out_vld_r || out_tready);
  assign in_tready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_tready) begin
      in_vld_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      in_ev_r   <= in_tdata[3:0];
      in_hint_r <= in_tdata[6:4];
    end
  end

  clfsm_decode u_decode (
    .cur_state     (cam_state_r),
    .req_type      (in_ev_r),
    .fallback_hint (in_hint_r),
    .res           (dec_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cam_state_r <= ST_IDLE;
      out_vld_r   <= 1'b0;
    end else begin
      if (adv) begin
        cam_state_r <= dec_res.next_state;
        out_vld_r   <= 1'b1;
      end else if (out_tready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= dec_res;
    end
  end

  assign out_tvalid = out_vld_r;
  assign out_tdata  = {1'b0,
                       out_res_r.fallback_cause,
                       out_res_r.fallback_valid,
                       out_res_r.stop_stall_watchdog,
                       out_res_r.start_stall_watchdog,
                       out_res_r.stop_first_watchdog,
                       out_res_r.start_first_watchdog,
                       out_res_r.stop_retry,
                       out_res_r.start_retry,
                       out_res_r.close_device,
                       out_res_r.start_open,
                       out_res_r.next_state};

  `CLF_ASSERT_NOW(a_never_failed, clk, rst_n, 1'b1, cam_state_r != ST_FAILED, "entered failed state")
  `CLF_ASSERT_NEXT(a_shutdown_idle, clk, rst_n, adv && in_ev_r == EV_SHUTDOWN, cam_state_r == ST_IDLE, "shutdown did not force idle")
  `CLF_ASSERT_NEXT(a_state_hold, clk, rst_n, !adv, $stable(cam_state_r), "state moved without an event")
  `CLF_ASSERT_NEXT(a_out_tracks_state, clk, rst_n, adv, out_vld_r && out_tdata[2:0] == cam_state_r, "result state differs from state register")

endmodule

`default_nettype wire
